@@ rtl/cds_pkg.sv @@
// ----------------------------------------------------------------------------
// cds_pkg
// shared types, codes and calendar helpers for the date stepper
// ----------------------------------------------------------------------------
`default_nettype none

package cds_pkg;

  localparam int MAX_YEAR       = 9999;
  localparam int YEAR_FIELD_MAX = 16383;
  localparam int YEAR_CAP_INT   = (MAX_YEAR < YEAR_FIELD_MAX) ? MAX_YEAR : YEAR_FIELD_MAX;
  localparam logic [13:0] YEAR_CAP   = 14'(YEAR_CAP_INT);
  localparam logic [13:0] RESET_YEAR = 14'd2000;

  // divisibility by 25 through the modular inverse of 25 mod 2^14
  localparam logic [13:0] INV25     = 14'd7209;
  localparam logic [13:0] DIV25_LIM = 14'd655;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ACT_FWD  = 2'd0,
    ACT_BWD  = 2'd1,
    ACT_LOAD = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    UNIT_DAY   = 2'd0,
    UNIT_MONTH = 2'd1,
    UNIT_YEAR  = 2'd2
  } unit_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LOAD = 2'd1,
    ST_BOUND    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_NOP    = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_REJECT = 2'd2,
    CMD_STEP   = 2'd3
  } cmd_kind_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } back_state_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        backward;
    unit_t       unit;
    logic [15:0] count;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } cmd_t;

  function automatic logic is_leap(input logic [13:0] y);
    logic [27:0] prod;
    logic        div25;
    prod  = 28'(y) * 28'(INV25);
    div25 = (prod[13:0] <= DIV25_LIM);
    return ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2: len = leap ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

@@ rtl/cds_front.sv @@
// ----------------------------------------------------------------------------
// cds_front
// accepts input transactions, checks loads and classifies them into commands
// ----------------------------------------------------------------------------
`default_nettype none

module cds_front (
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [1:0]     in_action,
  input  wire logic [1:0]     in_unit,
  input  wire logic [15:0]    in_count,
  input  wire logic [4:0]     in_load_day,
  input  wire logic [3:0]     in_load_month,
  input  wire logic [13:0]    in_load_year,
  input  wire logic           q_full,
  output logic                q_push,
  output cds_pkg::cmd_t       q_cmd
);

  logic       load_leap;
  logic [4:0] load_len;
  logic       load_good;
  logic       step_sel;

  assign in_ready  = !q_full;
  assign q_push    = in_valid && !q_full;

  assign load_leap = cds_pkg::is_leap(in_load_year);
  assign load_len  = cds_pkg::month_len(in_load_month, load_leap);
  assign load_good = (in_load_month >= 4'd1) && (in_load_month <= 4'd12) &&
                     (in_load_day != 5'd0) && (in_load_day <= load_len) &&
                     (in_load_year <= cds_pkg::YEAR_CAP);

  assign step_sel  = ((in_action == cds_pkg::ACT_FWD) || (in_action == cds_pkg::ACT_BWD)) &&
                     ((in_unit == cds_pkg::UNIT_DAY) || (in_unit == cds_pkg::UNIT_MONTH) ||
                      (in_unit == cds_pkg::UNIT_YEAR)) &&
                     (in_count != 16'd0);

  always_comb begin
    q_cmd.backward = (in_action == cds_pkg::ACT_BWD);
    q_cmd.unit     = cds_pkg::unit_t'(in_unit);
    q_cmd.count    = in_count;
    q_cmd.day      = in_load_day;
    q_cmd.month    = in_load_month;
    q_cmd.year     = in_load_year;
    if (in_action == cds_pkg::ACT_LOAD) begin
      q_cmd.kind = load_good ? cds_pkg::CMD_LOAD : cds_pkg::CMD_REJECT;
    end else if (step_sel) begin
      q_cmd.kind = cds_pkg::CMD_STEP;
    end else begin
      q_cmd.kind = cds_pkg::CMD_NOP;
    end
  end

endmodule

`default_nettype wire

@@ rtl/cds_queue.sv @@
// ----------------------------------------------------------------------------
// cds_queue
// small register queue of commands between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module cds_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire cds_pkg::cmd_t  push_cmd,
  output logic                full,
  input  wire logic           pop,
  output cds_pkg::cmd_t       pop_cmd,
  output logic                not_empty
);

  cds_pkg::cmd_t                   entry_r [cds_pkg::QDEPTH];
  logic [cds_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [cds_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [cds_pkg::QCNT_W-1:0]      fill_r, fill_nxt;
  logic                            do_pop;

  assign full      = (fill_r == cds_pkg::QCNT_W'(cds_pkg::QDEPTH));
  assign not_empty = (fill_r != '0);
  assign pop_cmd   = entry_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == cds_pkg::QPTR_W'(cds_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == cds_pkg::QPTR_W'(cds_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (!push && do_pop) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

@@ rtl/cds_back.sv @@
// ----------------------------------------------------------------------------
// cds_back
// holds the date, runs commands one unit step per cycle, registers results
// ----------------------------------------------------------------------------
`default_nettype none

module cds_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire cds_pkg::cmd_t  q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [4:0]          out_day_out,
  output logic [3:0]          out_month_out,
  output logic [13:0]         out_year_out,
  output logic [1:0]          out_status
);

  cds_pkg::back_state_t state_r, state_nxt;
  logic [4:0]           day_r, day_nxt;
  logic [3:0]           month_r, month_nxt;
  logic [13:0]          year_r, year_nxt;
  logic [15:0]          steps_r, steps_nxt;
  logic                 bwd_r, bwd_nxt;
  cds_pkg::unit_t       unit_r, unit_nxt;

  logic                 ovalid_r, ovalid_nxt;
  logic [4:0]           oday_r, oday_nxt;
  logic [3:0]           omonth_r, omonth_nxt;
  logic [13:0]          oyear_r, oyear_nxt;
  cds_pkg::status_t     ostat_r, ostat_nxt;

  logic                 cur_leap;
  logic [4:0]           cur_len;
  logic                 step_ok;
  logic [4:0]           s_day;
  logic [3:0]           s_month;
  logic [13:0]          s_year;

  assign cur_leap = cds_pkg::is_leap(year_r);
  assign cur_len  = cds_pkg::month_len(month_r, cur_leap);

  // one unit step on the held date
  always_comb begin
    step_ok = 1'b1;
    s_day   = day_r;
    s_month = month_r;
    s_year  = year_r;
    case (unit_r)
      cds_pkg::UNIT_DAY: begin
        if (!bwd_r) begin
          if (day_r < cur_len) begin
            s_day = day_r + 5'd1;
          end else if (month_r < 4'd12) begin
            s_month = month_r + 4'd1;
            s_day   = 5'd1;
          end else if (year_r < cds_pkg::YEAR_CAP) begin
            s_year  = year_r + 14'd1;
            s_month = 4'd1;
            s_day   = 5'd1;
          end else begin
            step_ok = 1'b0;
          end
        end else begin
          if (day_r > 5'd1) begin
            s_day = day_r - 5'd1;
          end else if (month_r > 4'd1) begin
            s_month = month_r - 4'd1;
            s_day   = cds_pkg::month_len(month_r - 4'd1, cur_leap);
          end else if (year_r != 14'd0) begin
            s_year  = year_r - 14'd1;
            s_month = 4'd12;
            s_day   = 5'd31;
          end else begin
            step_ok = 1'b0;
          end
        end
      end
      cds_pkg::UNIT_MONTH: begin
        if (!bwd_r) begin
          if (month_r < 4'd12) begin
            s_month = month_r + 4'd1;
          end else if (year_r < cds_pkg::YEAR_CAP) begin
            s_year  = year_r + 14'd1;
            s_month = 4'd1;
          end else begin
            step_ok = 1'b0;
          end
        end else begin
          if (month_r > 4'd1) begin
            s_month = month_r - 4'd1;
          end else if (year_r != 14'd0) begin
            s_year  = year_r - 14'd1;
            s_month = 4'd12;
          end else begin
            step_ok = 1'b0;
          end
        end
      end
      cds_pkg::UNIT_YEAR: begin
        if (!bwd_r) begin
          if (year_r < cds_pkg::YEAR_CAP) begin
            s_year = year_r + 14'd1;
          end else begin
            step_ok = 1'b0;
          end
        end else begin
          if (year_r != 14'd0) begin
            s_year = year_r - 14'd1;
          end else begin
            step_ok = 1'b0;
          end
        end
      end
      default: begin
        step_ok = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    day_nxt    = day_r;
    month_nxt  = month_r;
    year_nxt   = year_r;
    steps_nxt  = steps_r;
    bwd_nxt    = bwd_r;
    unit_nxt   = unit_r;
    ovalid_nxt = ovalid_r && !out_ready;
    oday_nxt   = oday_r;
    omonth_nxt = omonth_r;
    oyear_nxt  = oyear_r;
    ostat_nxt  = ostat_r;
    q_pop      = 1'b0;
    case (state_r)
      cds_pkg::BK_IDLE: begin
        if (q_valid && (!ovalid_r || out_ready)) begin
          q_pop      = 1'b1;
          oday_nxt   = day_r;
          omonth_nxt = month_r;
          oyear_nxt  = year_r;
          ostat_nxt  = cds_pkg::ST_OK;
          case (q_cmd.kind)
            cds_pkg::CMD_LOAD: begin
              day_nxt    = q_cmd.day;
              month_nxt  = q_cmd.month;
              year_nxt   = q_cmd.year;
              oday_nxt   = q_cmd.day;
              omonth_nxt = q_cmd.month;
              oyear_nxt  = q_cmd.year;
              ovalid_nxt = 1'b1;
            end
            cds_pkg::CMD_REJECT: begin
              ostat_nxt  = cds_pkg::ST_BAD_LOAD;
              ovalid_nxt = 1'b1;
            end
            cds_pkg::CMD_STEP: begin
              steps_nxt = q_cmd.count;
              bwd_nxt   = q_cmd.backward;
              unit_nxt  = q_cmd.unit;
              state_nxt = cds_pkg::BK_RUN;
            end
            default: begin
              ovalid_nxt = 1'b1;
            end
          endcase
        end
      end
      cds_pkg::BK_RUN: begin
        if (step_ok) begin
          day_nxt   = s_day;
          month_nxt = s_month;
          year_nxt  = s_year;
          steps_nxt = steps_r - 16'd1;
          if (steps_r == 16'd1) begin
            oday_nxt   = s_day;
            omonth_nxt = s_month;
            oyear_nxt  = s_year;
            ostat_nxt  = cds_pkg::ST_OK;
            ovalid_nxt = 1'b1;
            state_nxt  = cds_pkg::BK_IDLE;
          end
        end else begin
          steps_nxt  = 16'd0;
          oday_nxt   = day_r;
          omonth_nxt = month_r;
          oyear_nxt  = year_r;
          ostat_nxt  = cds_pkg::ST_BOUND;
          ovalid_nxt = 1'b1;
          state_nxt  = cds_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = cds_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= cds_pkg::BK_IDLE;
      day_r    <= 5'd1;
      month_r  <= 4'd1;
      year_r   <= cds_pkg::RESET_YEAR;
      steps_r  <= 16'd0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      day_r    <= day_nxt;
      month_r  <= month_nxt;
      year_r   <= year_nxt;
      steps_r  <= steps_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bwd_r    <= bwd_nxt;
    unit_r   <= unit_nxt;
    oday_r   <= oday_nxt;
    omonth_r <= omonth_nxt;
    oyear_r  <= oyear_nxt;
    ostat_r  <= ostat_nxt;
  end

  assign out_valid     = ovalid_r;
  assign out_day_out   = oday_r;
  assign out_month_out = omonth_r;
  assign out_year_out  = oyear_r;
  assign out_status    = ostat_r;

endmodule

`default_nettype wire

@@ rtl/calendar_date_stepper.sv @@
// ----------------------------------------------------------------------------
// calendar_date_stepper
// gregorian date register that loads a date or steps it by days, months, years
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   in_      | in_valid / in_ready  | action, unit, count, load_day/month/year
//   out_     | out_valid / out_ready| day_out, month_out, year_out, status
//
// a load, a rejected load or a no-op is answered from the idle state of the back end
// a step transaction applies one unit step per cycle to the date, stopping
// early when the year bound is hit
// out_valid rises at the earliest once the command has passed the queue and the output register
// synchronous active-low reset sets the date to 1/1/2000 and empties the queue
// a two-entry queue lets the front accept while the back end or output stalls
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_stepper (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  input  wire logic [1:0]  in_unit,
  input  wire logic [15:0] in_count,
  input  wire logic [4:0]  in_load_day,
  input  wire logic [3:0]  in_load_month,
  input  wire logic [13:0] in_load_year,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [4:0]       out_day_out,
  output logic [3:0]       out_month_out,
  output logic [13:0]      out_year_out,
  output logic [1:0]       out_status
);

  logic          q_full;
  logic          q_push;
  cds_pkg::cmd_t q_in_cmd;
  logic          q_pop;
  cds_pkg::cmd_t q_out_cmd;
  logic          q_not_empty;

  cds_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_unit       (in_unit),
    .in_count      (in_count),
    .in_load_day   (in_load_day),
    .in_load_month (in_load_month),
    .in_load_year  (in_load_year),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_in_cmd)
  );

  cds_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_in_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_cmd   (q_out_cmd),
    .not_empty (q_not_empty)
  );

  cds_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_not_empty),
    .q_cmd         (q_out_cmd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_day_out   (out_day_out),
    .out_month_out (out_month_out),
    .out_year_out  (out_year_out),
    .out_status    (out_status)
  );

endmodule

`default_nettype wire

@@ test/calendar_date_stepper_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_date_stepper_tb
// self-checking bench: directed and random loads and steps in bursts, with
// output back-pressure, checked in order against a scoreboard copy of the date
// ----------------------------------------------------------------------------

module calendar_date_stepper_tb;

  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam logic [1:0] UNIT_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1200;
  localparam int DIRECTED_ITEMS = 27;
  localparam int HOLD_AT_RESULT = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 1000000;

  typedef struct packed {
    logic [1:0]  act;
    logic [1:0]  unit;
    logic [15:0] count;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } date_request_t;

  typedef struct packed {
    logic [4:0]       day;
    logic [3:0]       month;
    logic [13:0]      year;
    cds_pkg::status_t status;
  } date_result_t;

  class date_tracker;
    int unsigned day_now, month_now, year_now;
    date_result_t expected_dates[$];
    int unsigned n_checked, n_mismatch, n_loads, n_rejected, n_steps, n_bound;

    function new();
      day_now = 1;
      month_now = 1;
      year_now = 2000;
      n_checked = 0;
      n_mismatch = 0;
      n_loads = 0;
      n_rejected = 0;
      n_steps = 0;
      n_bound = 0;
    endfunction

    function bit leap_year(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function int unsigned days_in_month(int unsigned m, int unsigned y);
      case (m)
        1, 3, 5, 7, 8, 10, 12: return 31;
        4, 6, 9, 11: return 30;
        2: return leap_year(y) ? 29 : 28;
        default: return 0;
      endcase
    endfunction

    function bit shift_year(bit back);
      if (back) begin
        if (year_now == 0) return 1'b0;
        year_now--;
      end else begin
        if (year_now >= int'(cds_pkg::YEAR_CAP)) return 1'b0;
        year_now++;
      end
      return 1'b1;
    endfunction

    function bit shift_month(bit back);
      if (back) begin
        if (month_now > 1) begin
          month_now--;
          return 1'b1;
        end
        if (!shift_year(1'b1)) return 1'b0;
        month_now = 12;
      end else begin
        if (month_now < 12) begin
          month_now++;
          return 1'b1;
        end
        if (!shift_year(1'b0)) return 1'b0;
        month_now = 1;
      end
      return 1'b1;
    endfunction

    // a day beyond the month length (after a month step) wraps on the next forward day
    function bit shift_day(bit back);
      if (back) begin
        if (day_now > 1) begin
          day_now--;
          return 1'b1;
        end
        if (!shift_month(1'b1)) return 1'b0;
        day_now = days_in_month(month_now, year_now);
      end else begin
        if (day_now < days_in_month(month_now, year_now)) begin
          day_now++;
          return 1'b1;
        end
        if (!shift_month(1'b0)) return 1'b0;
        day_now = 1;
      end
      return 1'b1;
    endfunction

    function void record_command(date_request_t rq);
      date_result_t res;
      bit back;
      bit moved;
      int unsigned left;
      res.status = cds_pkg::ST_OK;
      if (rq.act == cds_pkg::ACT_LOAD) begin
        n_loads++;
        if (rq.month >= 1 && rq.month <= 12 && rq.day >= 1 &&
            rq.day <= days_in_month(rq.month, rq.year) &&
            rq.year <= cds_pkg::YEAR_CAP) begin
          day_now = rq.day;
          month_now = rq.month;
          year_now = rq.year;
        end else begin
          res.status = cds_pkg::ST_BAD_LOAD;
          n_rejected++;
        end
      end else if ((rq.act == cds_pkg::ACT_FWD || rq.act == cds_pkg::ACT_BWD) &&
                   rq.unit != UNIT_UNUSED) begin
        n_steps++;
        back = (rq.act == cds_pkg::ACT_BWD);
        for (left = rq.count; left != 0; left--) begin
          case (rq.unit)
            cds_pkg::UNIT_DAY: moved = shift_day(back);
            cds_pkg::UNIT_MONTH: moved = shift_month(back);
            default: moved = shift_year(back);
          endcase
          if (!moved) begin
            res.status = cds_pkg::ST_BOUND;
            n_bound++;
            break;
          end
        end
      end
      res.day = 5'(day_now);
      res.month = 4'(month_now);
      res.year = 14'(year_now);
      expected_dates.push_back(res);
    endfunction

    function void check_date(logic [4:0] d, logic [3:0] m, logic [13:0] y, logic [1:0] s);
      date_result_t want;
      if (expected_dates.size() == 0) begin
        if (n_mismatch < 10)
          $display("%0t: unexpected result %0d/%0d/%0d status %0d", $realtime, d, m, y, s);
        n_mismatch++;
        return;
      end
      want = expected_dates.pop_front();
      n_checked++;
      if (d !== want.day || m !== want.month || y !== want.year || s !== want.status) begin
        if (n_mismatch < 10)
          $display({"%0t: result %0d mismatch: expected %0d/%0d/%0d status %0d,",
                    " got %0d/%0d/%0d status %0d"},
                   $realtime, n_checked, want.day, want.month, want.year, want.status,
                   d, m, y, s);
        n_mismatch++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_action;
  logic [1:0]  in_unit;
  logic [15:0] in_count;
  logic [4:0]  in_load_day;
  logic [3:0]  in_load_month;
  logic [13:0] in_load_year;
  logic        out_valid;
  logic        out_ready;
  logic [4:0]  out_day_out;
  logic [3:0]  out_month_out;
  logic [13:0] out_year_out;
  logic [1:0]  out_status;

  date_tracker tracker = new();
  int unsigned burst_left = 0;
  int unsigned in_blocked_cycles = 0;

  calendar_date_stepper i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_unit       (in_unit),
    .in_count      (in_count),
    .in_load_day   (in_load_day),
    .in_load_month (in_load_month),
    .in_load_year  (in_load_year),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_day_out   (out_day_out),
    .out_month_out (out_month_out),
    .out_year_out  (out_year_out),
    .out_status    (out_status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_ready) in_blocked_cycles++;
  end

  initial begin
    #100_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ignored fields carry random values too
  function automatic date_request_t noise_request();
    date_request_t rq;
    rq.act = 2'($urandom);
    rq.unit = 2'($urandom);
    rq.count = 16'($urandom);
    rq.day = 5'($urandom);
    rq.month = 4'($urandom);
    rq.year = 14'($urandom);
    return rq;
  endfunction

  function automatic date_request_t make_load(int unsigned d, int unsigned m, int unsigned y);
    date_request_t rq;
    rq = noise_request();
    rq.act = cds_pkg::ACT_LOAD;
    rq.day = 5'(d);
    rq.month = 4'(m);
    rq.year = 14'(y);
    return rq;
  endfunction

  function automatic date_request_t make_step(logic [1:0] act, logic [1:0] unit,
                                              int unsigned count);
    date_request_t rq;
    rq = noise_request();
    rq.act = act;
    rq.unit = unit;
    rq.count = 16'(count);
    return rq;
  endfunction

  function automatic date_request_t random_request();
    date_request_t rq;
    int unsigned pick;
    int unsigned size_pick;
    int unsigned m;
    int unsigned y;
    rq = noise_request();
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      m = $urandom_range(1, 12);
      if (pick < 6)
        y = $urandom_range(0, 1) ? $urandom_range(0, 3) :
            $urandom_range(cds_pkg::YEAR_CAP - 3, cds_pkg::YEAR_CAP);
      else
        y = $urandom_range(0, cds_pkg::YEAR_CAP);
      rq = make_load($urandom_range(1, tracker.days_in_month(m, y)), m, y);
    end else if (pick < 30) begin
      rq.act = cds_pkg::ACT_LOAD;
    end else if (pick < 34) begin
      if ($urandom_range(0, 1)) rq.act = ACT_UNUSED;
      else begin
        rq.act = 2'($urandom_range(cds_pkg::ACT_FWD, cds_pkg::ACT_BWD));
        rq.unit = UNIT_UNUSED;
      end
    end else begin
      rq.act = 2'($urandom_range(cds_pkg::ACT_FWD, cds_pkg::ACT_BWD));
      rq.unit = 2'($urandom_range(cds_pkg::UNIT_DAY, cds_pkg::UNIT_YEAR));
      size_pick = $urandom_range(0, 999);
      if (size_pick < 5) rq.count = 16'($urandom);
      else if (size_pick < 60) rq.count = 16'($urandom_range(0, 400));
      else if (rq.unit == cds_pkg::UNIT_DAY) rq.count = 16'($urandom_range(0, 40));
      else if (rq.unit == cds_pkg::UNIT_MONTH) rq.count = 16'($urandom_range(0, 30));
      else rq.count = 16'($urandom_range(0, 12));
    end
    return rq;
  endfunction

  task automatic drive_request(input date_request_t rq);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 7))
        0, 1: gap = 0;
        2: gap = $urandom_range(20, 60);
        default: gap = $urandom_range(1, 8);
      endcase
      if (gap != 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_action = rq.act;
    in_unit = rq.unit;
    in_count = rq.count;
    in_load_day = rq.day;
    in_load_month = rq.month;
    in_load_year = rq.year;
    do @(posedge clk); while (!in_ready);
    tracker.record_command(rq);
  endtask

  // result side: stall pattern changes per window, one long hold-off
  initial begin
    int unsigned mode;
    int unsigned window;
    int unsigned hold;
    bit held;
    mode = 0;
    window = 0;
    hold = 0;
    held = 1'b0;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (window == 0) begin
        mode = $urandom_range(0, 3);
        window = $urandom_range(20, 120);
      end
      window--;
      if (hold != 0) begin
        hold--;
        out_ready = 1'b0;
      end else if (!held && tracker.n_checked >= HOLD_AT_RESULT) begin
        held = 1'b1;
        hold = HOLD_CYCLES;
        out_ready = 1'b0;
      end else begin
        case (mode)
          0: out_ready = 1'b1;
          1: out_ready = ($urandom_range(0, 3) != 0);
          2: out_ready = ($urandom_range(0, 3) == 0);
          default: out_ready = window[2];
        endcase
      end
      @(posedge clk);
      if (out_valid && out_ready)
        tracker.check_date(out_day_out, out_month_out, out_year_out, out_status);
    end
  end

  initial begin
    int unsigned guard;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = '0;
    in_unit = '0;
    in_count = '0;
    in_load_day = '0;
    in_load_month = '0;
    in_load_year = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // zero count, leap rules, year 0
    drive_request(make_step(cds_pkg::ACT_FWD, cds_pkg::UNIT_DAY, 0));
    drive_request(make_load(29, 2, 2000));
    drive_request(make_load(29, 2, 1900));
    drive_request(make_load(29, 2, 2004));
    drive_request(make_load(29, 2, 0));
    drive_request(make_step(cds_pkg::ACT_BWD, cds_pkg::UNIT_DAY, 60));
    // rejected loads
    drive_request(make_load(0, 5, 2020));
    drive_request(make_load(10, 0, 2020));
    drive_request(make_load(31, 15, 16383));
    drive_request(make_load(31, 4, 2020));
    drive_request(make_load(1, 1, cds_pkg::YEAR_CAP + 1));
    // upper year bound
    drive_request(make_load(31, 12, cds_pkg::YEAR_CAP));
    drive_request(make_step(cds_pkg::ACT_FWD, cds_pkg::UNIT_DAY, 1));
    drive_request(make_step(cds_pkg::ACT_FWD, cds_pkg::UNIT_MONTH, 1));
    // day left past the end of a shorter month
    drive_request(make_load(31, 1, 2001));
    drive_request(make_step(cds_pkg::ACT_FWD, cds_pkg::UNIT_MONTH, 1));
    drive_request(make_step(cds_pkg::ACT_FWD, cds_pkg::UNIT_DAY, 1));
    drive_request(make_load(31, 3, 2001));
    drive_request(make_step(cds_pkg::ACT_BWD, cds_pkg::UNIT_MONTH, 1));
    drive_request(make_step(cds_pkg::ACT_BWD, cds_pkg::UNIT_DAY, 1));
    // unused selectors
    drive_request(make_step(ACT_UNUSED, cds_pkg::UNIT_DAY, 5));
    drive_request(make_step(cds_pkg::ACT_FWD, UNIT_UNUSED, 7));
    // reaching and passing the bounds, largest count
    drive_request(make_load(1, 1, cds_pkg::YEAR_CAP - 1));
    drive_request(make_step(cds_pkg::ACT_FWD, cds_pkg::UNIT_YEAR, 1));
    drive_request(make_step(cds_pkg::ACT_FWD, cds_pkg::UNIT_YEAR, 65535));
    drive_request(make_step(cds_pkg::ACT_BWD, cds_pkg::UNIT_YEAR, 65535));
    drive_request(make_step(cds_pkg::ACT_FWD, cds_pkg::UNIT_DAY, 65535));

    repeat (RANDOM_ITEMS) drive_request(random_request());
    @(negedge clk);
    in_valid = 1'b0;

    guard = 0;
    while (tracker.expected_dates.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (guard >= DRAIN_LIMIT) begin
      $display("Regression FAIL");
    end else begin
      repeat (20) @(posedge clk);
      $display("covered %0d transactions: %0d loads (%0d rejected), %0d steps (%0d at a bound)",
               RANDOM_ITEMS + DIRECTED_ITEMS, tracker.n_loads, tracker.n_rejected,
               tracker.n_steps, tracker.n_bound);
      $display("%0d results checked, %0d mismatches, input held off for %0d cycles",
               tracker.n_checked, tracker.n_mismatch, in_blocked_cycles);
      if (tracker.n_mismatch == 0 && tracker.expected_dates.size() == 0) begin
        $display("Regression PASS");
      end else begin
        $display("Regression FAIL");
      end
    end
    $finish;
  end

endmodule

@@ calendar_date_stepper.f @@
rtl/cds_pkg.sv
rtl/cds_front.sv
rtl/cds_queue.sv
rtl/cds_back.sv
rtl/calendar_date_stepper.sv
test/calendar_date_stepper_tb.sv
